// ----- design/first_fit_heap_allocator_assert.svh -----
// assertion macros shared by the allocator's modules
// expects signals named clk and rst in the including module
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
// condition must hold in the same cycle as the trigger
`define FFHA_ASSERT_NOW(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("allocator check failed");
// condition must hold in the cycle after the trigger
`define FFHA_ASSERT_NXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("allocator check failed");
`else
`define FFHA_ASSERT_NOW(label, trig, cond)
`define FFHA_ASSERT_NXT(label, trig, cond)
`endif
`endif

// ----- design/ffha_pkg.sv -----
// shared types, codes and constants of the first-fit heap allocator
// no dependencies
package ffha_pkg;

  localparam int POOL_BYTES_DEF   = 65536;
  localparam int ALIGN_BYTES_DEF  = 8;
  localparam int HEADER_BYTES_DEF = 24;

  // header store defaults for the generic ram (size field plus free mark)
  localparam int HDR_W_DEF     = 18;
  localparam int HDR_DEPTH_DEF = 8192;

  localparam int REQ_W = 17;
  localparam int OFF_W = 16;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef struct packed {
    logic             command;
    logic [REQ_W-1:0] request_size;
    logic [OFF_W-1:0] free_offset;
  } ffha_req_t;

  typedef struct packed {
    logic             success;
    logic [OFF_W-1:0] payload_offset;
    logic [REQ_W-1:0] granted_size;
  } ffha_rsp_t;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_FIRST,
    RD_NEXT
  } ffha_rd_op_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_INIT,
    WR_ALLOC,
    WR_SPLIT,
    WR_MERGE
  } ffha_wr_op_t;

  typedef enum logic [2:0] {
    WALK_HOLD,
    WALK_START,
    WALK_ADVANCE,
    WALK_HIT,
    WALK_MERGE
  } ffha_walk_op_t;

  typedef enum logic [1:0] {
    RES_KEEP,
    RES_FAIL,
    RES_ALLOC,
    RES_FREE
  } ffha_res_op_t;

  typedef struct packed {
    logic          capture;
    ffha_rd_op_t   rd_op;
    ffha_wr_op_t   wr_op;
    ffha_walk_op_t walk_op;
    ffha_res_op_t  res_op;
    logic          load_out;
  } ffha_cmd_t;

  typedef struct packed {
    logic free_cmd;
    logic bad_req;
    logic fit;
    logic split;
    logic hit;
    logic walk_end;
    logic out_free;
  } ffha_sts_t;

  // trailing zero count, used to find the common power-of-two grain of block starts
  function automatic int ffha_ctz(input int unsigned v);
    int          n;
    int unsigned w;
    n = 0;
    w = v;
    while (w[0] == 1'b0 && n < 31) begin
      w = w >> 1;
      n = n + 1;
    end
    return n;
  endfunction

endpackage

// ----- design/ffha_req_if.sv -----
// request channel of the allocator: valid, ready and one request item
// depends on ffha_pkg
interface ffha_req_if
  import ffha_pkg::*;
();
  logic      valid;
  logic      ready;
  ffha_req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/ffha_rsp_if.sv -----
// response channel of the allocator: valid, ready and one result item
// depends on ffha_pkg
interface ffha_rsp_if
  import ffha_pkg::*;
();
  logic      valid;
  logic      ready;
  ffha_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/ffha_ram.sv -----
// generic single-write, single-read ram with registered read data
// depends on ffha_pkg for default sizes
module ffha_ram
  import ffha_pkg::*;
#(
  parameter int WIDTH = HDR_W_DEF,
  parameter int DEPTH = HDR_DEPTH_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/ffha_datapath.sv -----
// allocator datapath: request capture, size rounding, block walk registers,
// header write formatting and the result register; depends on ffha_pkg
module ffha_datapath
  import ffha_pkg::*;
#(
  parameter int POOL_BYTES   = POOL_BYTES_DEF,
  parameter int ALIGN_BYTES  = ALIGN_BYTES_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF,
  localparam int ADDR_W = $clog2(POOL_BYTES + 1),
  localparam int HW     = ADDR_W + 1,
  localparam int SH     = ffha_ctz(HEADER_BYTES | ALIGN_BYTES),
  localparam int DEPTH  = (POOL_BYTES + (1 << SH) - 1) >> SH,
  localparam int IDX_W  = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  ffha_cmd_t        cmd,
  output ffha_sts_t        sts,
  input  ffha_req_t        req_data,
  output logic             rsp_valid,
  output ffha_rsp_t        rsp_data,
  input  logic             rsp_ready,
  output logic             ram_wr_en,
  output logic [IDX_W-1:0] ram_wr_addr,
  output logic [HW-1:0]    ram_wr_data,
  output logic             ram_rd_en,
  output logic [IDX_W-1:0] ram_rd_addr,
  input  logic [HW-1:0]    ram_rd_data
);

  localparam int X_W    = REQ_W + 1;
  localparam int WW     = ((ADDR_W > X_W) ? ADDR_W : X_W) + 1;
  localparam int RS     = X_W + 7;
  localparam int M_W    = RS - 1;
  localparam int PROD_W = X_W + M_W;
  localparam int Q_W    = PROD_W - RS;
  localparam logic [M_W-1:0] RECIP =
    M_W'(((64'd1 << RS) + 64'(ALIGN_BYTES) - 64'd1) / 64'(ALIGN_BYTES));
  localparam logic [WW-1:0] H_C    = WW'(HEADER_BYTES);
  localparam logic [WW-1:0] A_C    = WW'(ALIGN_BYTES);
  localparam logic [WW-1:0] POOL_C = WW'(POOL_BYTES);

  logic              op_q;
  logic [X_W-1:0]    x_q;
  logic              zero_q;
  logic              null_q;
  logic [WW-1:0]     target_q;
  logic [PROD_W-1:0] prod_q;
  logic [Q_W-1:0]    quot;
  logic [X_W-1:0]    asz_q;
  logic [WW-1:0]     asz_w;
  logic [WW-1:0]     cur;
  logic [HW-1:0]     hdr_q;
  logic [WW-1:0]     prev_start;
  logic [HW-1:0]     prev_hdr;
  logic              prev_valid;
  logic              next_valid;
  logic [ADDR_W-1:0] merged_q;
  ffha_rsp_t         res_q;

  logic              rd_free;
  logic [WW-1:0]     rd_size;
  logic [WW-1:0]     nxt;
  logic              nxt_in_pool;
  logic              next_free;
  logic [WW-1:0]     merged_sum;
  logic [WW-1:0]     rd_full;
  logic [WW-1:0]     wr_full;

  assign asz_w       = WW'(asz_q);
  assign quot        = prod_q[PROD_W-1 -: Q_W];
  assign rd_free     = ram_rd_data[HW-1];
  assign rd_size     = WW'(ram_rd_data[ADDR_W-1:0]);
  assign nxt         = cur + H_C + rd_size;
  assign nxt_in_pool = nxt < POOL_C;
  assign next_free   = next_valid && ram_rd_data[HW-1];
  assign merged_sum  = WW'(hdr_q[ADDR_W-1:0]) + (next_free ? (H_C + rd_size) : '0);

  // status toward the controller; walk flags are meaningful while a header is on the read port
  always_comb begin
    sts.free_cmd = (op_q == CMD_FREE);
    sts.bad_req  = (op_q == CMD_FREE) ? null_q : zero_q;
    sts.fit      = rd_free && (rd_size >= asz_w);
    sts.split    = rd_size >= (asz_w + H_C + A_C);
    sts.hit      = (cur == target_q);
    sts.walk_end = (op_q == CMD_FREE) ? ((nxt > target_q) || !nxt_in_pool) : !nxt_in_pool;
    sts.out_free = !rsp_valid || rsp_ready;
  end

  // request capture and size rounding (multiply by reciprocal, then by the alignment)
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q     <= req_data.command;
      x_q      <= X_W'(req_data.request_size) + X_W'(ALIGN_BYTES - 1);
      zero_q   <= (req_data.request_size == '0);
      null_q   <= (WW'(req_data.free_offset) < H_C);
      target_q <= WW'(req_data.free_offset) - H_C;
    end
    prod_q <= PROD_W'(x_q) * PROD_W'(RECIP);
    asz_q  <= X_W'(quot) * X_W'(ALIGN_BYTES);
  end

  // block walk registers
  always_ff @(posedge clk) begin
    case (cmd.walk_op)
      WALK_START: begin
        cur        <= '0;
        prev_valid <= 1'b0;
      end
      WALK_ADVANCE: begin
        prev_start <= cur;
        prev_hdr   <= ram_rd_data;
        prev_valid <= 1'b1;
        cur        <= nxt;
      end
      WALK_HIT: begin
        hdr_q      <= ram_rd_data;
        next_valid <= nxt_in_pool;
      end
      WALK_MERGE: begin
        merged_q <= ADDR_W'(merged_sum);
      end
      default: begin
      end
    endcase
    if (cmd.wr_op == WR_ALLOC) begin
      hdr_q <= ram_rd_data;
    end
  end

  // header reads
  always_comb begin
    ram_rd_en = 1'b0;
    rd_full   = '0;
    case (cmd.rd_op)
      RD_FIRST: begin
        ram_rd_en = 1'b1;
      end
      RD_NEXT: begin
        ram_rd_en = nxt_in_pool;
        rd_full   = nxt;
      end
      default: begin
      end
    endcase
  end
  assign ram_rd_addr = rd_full[SH +: IDX_W];

  // header writes
  always_comb begin
    ram_wr_en   = 1'b0;
    wr_full     = '0;
    ram_wr_data = '0;
    case (cmd.wr_op)
      WR_INIT: begin
        ram_wr_en   = 1'b1;
        ram_wr_data = {1'b1, ADDR_W'(POOL_C - H_C)};
      end
      WR_ALLOC: begin
        ram_wr_en   = 1'b1;
        wr_full     = cur;
        ram_wr_data = {1'b0, sts.split ? ADDR_W'(asz_w) : ADDR_W'(rd_size)};
      end
      WR_SPLIT: begin
        ram_wr_en   = 1'b1;
        wr_full     = cur + H_C + asz_w;
        ram_wr_data = {1'b1, ADDR_W'(WW'(hdr_q[ADDR_W-1:0]) - asz_w - H_C)};
      end
      WR_MERGE: begin
        ram_wr_en = 1'b1;
        if (prev_valid && prev_hdr[HW-1]) begin
          wr_full     = prev_start;
          ram_wr_data = {1'b1, ADDR_W'(WW'(prev_hdr[ADDR_W-1:0]) + H_C + WW'(merged_q))};
        end else begin
          wr_full     = cur;
          ram_wr_data = {1'b1, merged_q};
        end
      end
      default: begin
      end
    endcase
  end
  assign ram_wr_addr = wr_full[SH +: IDX_W];

  // pending result, then the output register
  always_ff @(posedge clk) begin
    case (cmd.res_op)
      RES_FAIL: begin
        res_q <= '0;
      end
      RES_ALLOC: begin
        res_q.success        <= 1'b1;
        res_q.payload_offset <= OFF_W'(cur + H_C);
        res_q.granted_size   <= REQ_W'(asz_q);
      end
      RES_FREE: begin
        res_q.success        <= 1'b1;
        res_q.payload_offset <= '0;
        res_q.granted_size   <= '0;
      end
      default: begin
      end
    endcase
    if (cmd.load_out) begin
      rsp_data <= res_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  `include "first_fit_heap_allocator_assert.svh"

  // rounded size is the smallest multiple of the alignment not below the request
  `FFHA_ASSERT_NXT(a_round_ok, cmd.walk_op == WALK_START, (asz_q <= x_q) && (asz_w + A_C > WW'(x_q)))
  `FFHA_ASSERT_NOW(a_rd_in_pool, ram_rd_en, rd_full < POOL_C)
  // every header written describes a block that ends inside the pool
  `FFHA_ASSERT_NOW(a_wr_in_chain, ram_wr_en, wr_full + H_C + WW'(ram_wr_data[ADDR_W-1:0]) <= POOL_C)

endmodule

// ----- design/ffha_ctrl.sv -----
// allocator controller: one-hot sequencer that drives the datapath by commands
// depends on ffha_pkg and the assertion macro header
module ffha_ctrl
  import ffha_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  ffha_sts_t sts,
  output ffha_cmd_t cmd
);

  typedef enum logic [8:0] {
    ST_INIT      = 9'b000000001,
    ST_IDLE      = 9'b000000010,
    ST_PREP      = 9'b000000100,
    ST_SCALE     = 9'b000001000,
    ST_WALK      = 9'b000010000,
    ST_SPLIT     = 9'b000100000,
    ST_FREE_NEXT = 9'b001000000,
    ST_FREE_WR   = 9'b010000000,
    ST_DONE      = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    req_ready    = 1'b0;
    cmd.capture  = 1'b0;
    cmd.rd_op    = RD_NONE;
    cmd.wr_op    = WR_NONE;
    cmd.walk_op  = WALK_HOLD;
    cmd.res_op   = RES_KEEP;
    cmd.load_out = 1'b0;
    case (state)
      ST_INIT: begin
        cmd.wr_op  = WR_INIT;
        state_next = ST_IDLE;
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_PREP;
        end
      end
      ST_PREP: begin
        if (sts.bad_req) begin
          cmd.res_op = RES_FAIL;
          state_next = ST_DONE;
        end else begin
          state_next = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd.rd_op   = RD_FIRST;
        cmd.walk_op = WALK_START;
        state_next  = ST_WALK;
      end
      ST_WALK: begin
        if (sts.free_cmd) begin
          if (sts.hit) begin
            cmd.walk_op = WALK_HIT;
            cmd.rd_op   = RD_NEXT;
            state_next  = ST_FREE_NEXT;
          end else if (sts.walk_end) begin
            cmd.res_op = RES_FAIL;
            state_next = ST_DONE;
          end else begin
            cmd.walk_op = WALK_ADVANCE;
            cmd.rd_op   = RD_NEXT;
          end
        end else begin
          if (sts.fit) begin
            cmd.wr_op  = WR_ALLOC;
            cmd.res_op = RES_ALLOC;
            state_next = sts.split ? ST_SPLIT : ST_DONE;
          end else if (sts.walk_end) begin
            cmd.res_op = RES_FAIL;
            state_next = ST_DONE;
          end else begin
            cmd.walk_op = WALK_ADVANCE;
            cmd.rd_op   = RD_NEXT;
          end
        end
      end
      ST_SPLIT: begin
        cmd.wr_op  = WR_SPLIT;
        state_next = ST_DONE;
      end
      ST_FREE_NEXT: begin
        cmd.walk_op = WALK_MERGE;
        state_next  = ST_FREE_WR;
      end
      ST_FREE_WR: begin
        cmd.wr_op  = WR_MERGE;
        cmd.res_op = RES_FREE;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

  `include "first_fit_heap_allocator_assert.svh"

  `FFHA_ASSERT_NOW(a_load_needs_slot, cmd.load_out, sts.out_free)
  `FFHA_ASSERT_NOW(a_no_port_clash, cmd.wr_op != WR_NONE, cmd.rd_op == RD_NONE)
  `FFHA_ASSERT_NOW(a_split_after_alloc, cmd.wr_op == WR_SPLIT, $past(cmd.wr_op) == WR_ALLOC)

endmodule

// ----- design/first_fit_heap_allocator.sv -----
// top level of the first-fit heap allocator with split and coalesce
// depends on ffha_pkg, ffha_req_if, ffha_rsp_if, ffha_ram, ffha_datapath, ffha_ctrl
//
//   channel  dir  payload                                    accepted when
//   req      in   command, request_size, free_offset         req.valid && req.ready
//   rsp      out  success, payload_offset, granted_size      rsp.valid && rsp.ready
//
// one item at a time; headers are walked one per cycle through the header ram read port
// allocate: prep, scale, one walk step per block visited, a split step when split, then done
// free: prep, scale, one walk step per block up to the freed one, free-next, free-write, then done
// reset: the init state writes the first header (whole pool free); req.ready stays low meanwhile
// the result sits in an output register: a new item is taken while it waits, and a
// finished item holds in the controller until that register is free
module first_fit_heap_allocator
  import ffha_pkg::*;
#(
  parameter int POOL_BYTES   = POOL_BYTES_DEF,
  parameter int ALIGN_BYTES  = ALIGN_BYTES_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input logic        clk,
  input logic        rst,
  ffha_req_if.sink   req,
  ffha_rsp_if.source rsp
);

  // header word: free mark over a size field wide enough for the pool
  localparam int ADDR_W = $clog2(POOL_BYTES + 1);
  localparam int HW     = ADDR_W + 1;
  // block starts are multiples of the power-of-two grain shared by header and alignment
  localparam int SH     = ffha_ctz(HEADER_BYTES | ALIGN_BYTES);
  localparam int DEPTH  = (POOL_BYTES + (1 << SH) - 1) >> SH;
  localparam int IDX_W  = $clog2(DEPTH);

  ffha_cmd_t        cmd;
  ffha_sts_t        sts;
  logic             ram_wr_en;
  logic [IDX_W-1:0] ram_wr_addr;
  logic [HW-1:0]    ram_wr_data;
  logic             ram_rd_en;
  logic [IDX_W-1:0] ram_rd_addr;
  logic [HW-1:0]    ram_rd_data;
  logic             rsp_valid;
  ffha_rsp_t        rsp_data;

  // sequencer: owns the request handshake and issues one command set per cycle
  ffha_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: size rounding, header walk, header formatting, result register
  ffha_datapath #(
    .POOL_BYTES   (POOL_BYTES),
    .ALIGN_BYTES  (ALIGN_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .req_data    (req.data),
    .rsp_valid   (rsp_valid),
    .rsp_data    (rsp_data),
    .rsp_ready   (rsp.ready),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

  // block headers, indexed by block start over the grain; stale entries are never reached
  ffha_ram #(
    .WIDTH (HW),
    .DEPTH (DEPTH)
  ) u_hdr_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

endmodule
